/* rtl/assert_macros.svh */
// Assertion macros for the trapezoidal shaper RTL.
// Expects clk and rst (synchronous, active high) in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/tps_pkg.sv */
// Shared types and constants for the trapezoidal pulse shaper.
// No dependencies; used by every module of the block.
`default_nettype none

package tps_pkg;

  localparam int MAX_DELAY   = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_BITS = $clog2(MAX_DELAY);
  localparam int CNT_BITS  = $clog2(MAX_DELAY + 1);
  localparam int DLY_BITS  = 9;
  localparam int CMP_BITS  = ((CNT_BITS > DLY_BITS) ? CNT_BITS : DLY_BITS) + 1;
  localparam int DIFF_BITS = SAMPLE_BITS + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_ADDR_BITS-1:0] REG_RISE_LEN    = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PEAK_DELAY  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DECAY_CONST = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_MODE   = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OUT_GAIN    = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          chan_start;
  } in_t;

  typedef struct packed {
    logic signed [31:0] shaped;
    logic               clipped;
  } out_t;

  typedef struct packed {
    logic [7:0]  rise_len;
    logic [7:0]  peak_delay;
    logic [15:0] decay_const;
    logic        step_mode;
    logic [31:0] out_gain;
  } cfg_t;

  // one classified sample: tap difference and channel restart flag
  typedef struct packed {
    logic signed [DIFF_BITS-1:0] diff;
    logic                        chan_start;
  } work_t;

endpackage

`default_nettype wire

/* rtl/trapezoidal_pulse_shaper_unit.sv */
// Top level of the trapezoidal pulse shaper: configuration registers, front
// end, work queue and back end. Depends on tps_pkg and the tps_* modules.
//
//   channel  | direction | handshake       | payload
//   ---------+-----------+-----------------+--------------------------------
//   input    | in        | push / full     | item   (sample, chan_start)
//   result   | out       | empty / pop     | result (shaped, clipped)
//   config   | in        | wr_en           | wr_addr, wr_data
//
// The front takes a new sample only once the last is committed: accept, three
// tap reads through the single read port of the delay memory, then the commit
// into the queue. The back works on one item at a time, with three passes
// through its shared 33x33 multiplier, and pops the next item only after the
// result register has taken the last result.
// Reset clears control and the accumulators at once; the delay memory is not
// cleared, since the fill count keeps unwritten entries from being read.
// Either side may stall: the two-entry queue and the result register decouple.
`default_nettype none

module trapezoidal_pulse_shaper_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire tps_pkg::in_t                       item,
  output logic                                    empty,
  input  wire logic                               pop,
  output tps_pkg::out_t                           result,
  input  wire logic                               wr_en,
  input  wire logic [tps_pkg::CFG_ADDR_BITS-1:0]  wr_addr,
  input  wire logic [tps_pkg::CFG_DATA_BITS-1:0]  wr_data
);

  tps_pkg::cfg_t  cfg;
  tps_pkg::work_t fq_data;
  tps_pkg::work_t qb_data;
  logic           fq_push;
  logic           fq_full;
  logic           qb_pop;
  logic           qb_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_len    <= 8'd10;
      cfg.peak_delay  <= 8'd20;
      cfg.decay_const <= 16'd2560;
      cfg.step_mode   <= 1'b0;
      cfg.out_gain    <= 32'd41943;
    end else if (wr_en) begin
      unique case (wr_addr)
        tps_pkg::REG_RISE_LEN:    cfg.rise_len    <= wr_data[7:0];
        tps_pkg::REG_PEAK_DELAY:  cfg.peak_delay  <= wr_data[7:0];
        tps_pkg::REG_DECAY_CONST: cfg.decay_const <= wr_data[15:0];
        tps_pkg::REG_STEP_MODE:   cfg.step_mode   <= wr_data[0];
        tps_pkg::REG_OUT_GAIN:    cfg.out_gain    <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  tps_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .cfg    (cfg),
    .q_push (fq_push),
    .q_full (fq_full),
    .q_data (fq_data)
  );

  tps_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (fq_push),
    .full    (fq_full),
    .wr_data (fq_data),
    .pop     (qb_pop),
    .empty   (qb_empty),
    .rd_data (qb_data)
  );

  tps_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_pop   (qb_pop),
    .q_empty (qb_empty),
    .q_data  (qb_data),
    .cfg     (cfg),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire

/* rtl/tps_queue.sv */
// Short register queue of work items between front and back.
// Depends on tps_pkg.
`default_nettype none

module tps_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire tps_pkg::work_t wr_data,
  input  wire logic          pop,
  output logic               empty,
  output tps_pkg::work_t     rd_data
);

  tps_pkg::work_t entries [tps_pkg::QUEUE_DEPTH];
  logic [tps_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [tps_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [tps_pkg::QCNT_BITS-1:0] count;
  logic do_push;
  logic do_pop;

  localparam logic [tps_pkg::QPTR_BITS-1:0] PTR_LAST =
    tps_pkg::QPTR_BITS'(tps_pkg::QUEUE_DEPTH - 1);

  assign full    = (count == tps_pkg::QCNT_BITS'(tps_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/tps_front.sv */
// Front end: accepts samples, reads the three delayed taps from the delay
// memory and forms the tap difference. Depends on tps_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tps_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire tps_pkg::in_t  item,
  input  wire tps_pkg::cfg_t cfg,
  output logic               q_push,
  input  wire logic          q_full,
  output tps_pkg::work_t     q_data
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_K    = 3'd1;
  localparam logic [2:0] F_L    = 3'd2;
  localparam logic [2:0] F_KL   = 3'd3;
  localparam logic [2:0] F_DONE = 3'd4;

  localparam logic [1:0] SEL_CUR   = 2'd0;
  localparam logic [1:0] SEL_FIRST = 2'd1;
  localparam logic [1:0] SEL_MEM   = 2'd2;

  localparam int SB = tps_pkg::SAMPLE_BITS;
  localparam int AB = tps_pkg::ADDR_BITS;
  localparam int CB = tps_pkg::CNT_BITS;
  localparam int MB = tps_pkg::CMP_BITS;
  localparam int DB = tps_pkg::DIFF_BITS;
  localparam logic [CB-1:0] CNT_MAX = CB'(tps_pkg::MAX_DELAY);
  localparam logic [AB-1:0] POS_LAST = AB'(tps_pkg::MAX_DELAY - 1);

  logic signed [SB-1:0] mem [tps_pkg::MAX_DELAY];
  logic signed [SB-1:0] rd_data;
  logic [AB-1:0]        rd_addr;
  logic                 rd_en;

  logic [2:0]           state;
  logic signed [SB-1:0] cur;
  logic                 cur_start;
  logic signed [SB-1:0] first_sample;
  logic [CB-1:0]        count;
  logic [AB-1:0]        wr_pos;
  logic [1:0]           tap_sel;
  logic signed [SB-1:0] vk;
  logic signed [SB-1:0] vl;

  logic [tps_pkg::DLY_BITS-1:0] dly;
  logic [MB-1:0]        dly_w;
  logic [MB-1:0]        pos_w;
  logic [MB-1:0]        idx_w;
  logic [1:0]           sel_next;
  logic signed [SB-1:0] tap_val;
  logic signed [DB-1:0] diff;
  logic                 accept;
  logic                 commit;

  assign accept = push && !full;
  assign full   = (state != F_IDLE);
  assign commit = (state == F_DONE) && !q_full;

  // delay of the tap that is read in this state
  always_comb begin
    case (state)
      F_K:     dly = tps_pkg::DLY_BITS'(cfg.rise_len);
      F_L:     dly = tps_pkg::DLY_BITS'(cfg.peak_delay);
      default: dly = tps_pkg::DLY_BITS'(cfg.rise_len) + tps_pkg::DLY_BITS'(cfg.peak_delay);
    endcase
  end

  assign dly_w = MB'(dly);
  assign pos_w = MB'(wr_pos);
  assign idx_w = (pos_w >= dly_w) ? pos_w - dly_w
                                  : pos_w + MB'(tps_pkg::MAX_DELAY) - dly_w;
  assign rd_addr = idx_w[AB-1:0];
  assign rd_en   = (state == F_K) || (state == F_L) || (state == F_KL);

  // a zero delay reads the current sample; taps reaching back past the channel start read the first sample
  always_comb begin
    if (dly_w == '0) begin
      sel_next = SEL_CUR;
    end else if (dly_w > MB'(count)) begin
      sel_next = SEL_FIRST;
    end else begin
      sel_next = SEL_MEM;
    end
  end

  always_comb begin
    case (tap_sel)
      SEL_CUR:   tap_val = cur;
      SEL_FIRST: tap_val = first_sample;
      default:   tap_val = rd_data;
    endcase
  end

  assign diff = DB'(cur) - DB'(vk) - DB'(vl) + DB'(tap_val);

  assign q_push          = commit;
  assign q_data.diff     = diff;
  assign q_data.chan_start = cur_start;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (commit) begin
      mem[wr_pos] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur       <= item.sample;
      cur_start <= item.chan_start;
    end
    if (rd_en) begin
      tap_sel <= sel_next;
    end
    if (state == F_L) begin
      vk <= tap_val;
    end
    if (state == F_KL) begin
      vl <= tap_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      first_sample <= '0;
      count        <= '0;
      wr_pos       <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (item.chan_start) begin
              first_sample <= item.sample;
              count        <= '0;
            end
            state <= F_K;
          end
        end
        F_K:  state <= F_L;
        F_L:  state <= F_KL;
        F_KL: state <= F_DONE;
        F_DONE: begin
          // hold until the queue has room
          if (commit) begin
            wr_pos <= (wr_pos == POS_LAST) ? '0 : wr_pos + 1'b1;
            if (count < CNT_MAX) begin
              count <= count + 1'b1;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_reads, push && !full, state == F_K)
  `ASSERT_IMPL(a_push_when_done, q_push, state == F_DONE && !q_full)
  `ASSERT_ALWAYS(a_count_bound, count <= CNT_MAX)

endmodule

`default_nettype wire

/* rtl/tps_back.sv */
// Back end: runs the two accumulators, scales by the output gain with one
// shared 33x33 multiplier and saturates. Depends on tps_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tps_back (
  input  wire logic           clk,
  input  wire logic           rst,
  output logic                q_pop,
  input  wire logic           q_empty,
  input  wire tps_pkg::work_t q_data,
  input  wire tps_pkg::cfg_t  cfg,
  input  wire logic           pop,
  output logic                empty,
  output tps_pkg::out_t       result
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DM   = 3'd1;
  localparam logic [2:0] B_ACC  = 3'd2;
  localparam logic [2:0] B_MLO  = 3'd3;
  localparam logic [2:0] B_MHI  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  localparam int DB = tps_pkg::DIFF_BITS;

  logic [2:0]           state;
  logic signed [DB-1:0] diff;
  logic                 start;
  logic signed [31:0]   diff_sum;
  logic [63:0]          shape_acc;
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   mul_p;
  logic [63:0]          plo;
  logic [63:0]          acc_add;
  logic signed [65:0]   hi_sum;
  logic [67:0]          quot;
  logic                 fits;
  tps_pkg::out_t        res_next;
  logic                 out_valid;
  logic                 load;

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign empty = !out_valid;
  assign load  = (state == B_OUT) && (!out_valid || pop);

  // shared multiplier operands
  always_comb begin
    unique case (state)
      B_DM: begin
        mul_a = 33'(diff);
        mul_b = $signed({17'b0, cfg.decay_const});
      end
      B_MLO: begin
        mul_a = $signed({1'b0, shape_acc[31:0]});
        mul_b = $signed({1'b0, cfg.out_gain});
      end
      B_MHI: begin
        mul_a = $signed({shape_acc[63], shape_acc[63:32]});
        mul_b = $signed({1'b0, cfg.out_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // s gains d*64 in step mode, else p*64 + d*M
  assign acc_add = cfg.step_mode ? (64'(diff) <<< 6)
                                 : (64'(diff_sum) <<< 6) + mul_p[63:0];

  // recombine the halves and take bits 30 and up of the 96-bit product
  assign hi_sum = mul_p + $signed({34'b0, plo[63:32]});
  assign quot   = {hi_sum, plo[31:30]};
  assign fits   = (&quot[67:31]) || !(|quot[67:31]);

  always_comb begin
    if (fits) begin
      res_next.shaped  = $signed(quot[31:0]);
      res_next.clipped = 1'b0;
    end else begin
      res_next.shaped  = quot[67] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      res_next.clipped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      diff  <= q_data.diff;
      start <= q_data.chan_start;
    end
    if (state == B_DM || state == B_MLO || state == B_MHI) begin
      mul_p <= mul_a * mul_b;
    end
    if (state == B_MHI) begin
      plo <= mul_p[63:0];
    end
    if (load) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      diff_sum  <= '0;
      shape_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            state <= B_DM;
          end
        end
        B_DM: begin
          // restart both accumulators on a channel start
          diff_sum <= (start ? 32'sd0 : diff_sum) + 32'(diff);
          if (start) begin
            shape_acc <= '0;
          end
          state <= B_ACC;
        end
        B_ACC: begin
          shape_acc <= shape_acc + acc_add;
          state     <= B_MLO;
        end
        B_MLO: state <= B_MHI;
        B_MHI: state <= B_OUT;
        B_OUT: begin
          if (load) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_pop_idle, q_pop, state == B_IDLE)
  `ASSERT_NEXT(a_pop_runs, q_pop, state == B_DM)
  `ASSERT_NEXT(a_out_wait, state == B_OUT && out_valid && !pop, state == B_OUT)
  `ASSERT_NEXT(a_load_done, load, state == B_IDLE && out_valid)

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for trapezoidal_pulse_shaper_unit.
// Predicts every shaped sample in-line from the tap, running-sum and scaling
// arithmetic. Depends on tps_pkg and the shaper RTL.
`timescale 1ns / 100ps

module testbench;

  localparam logic signed [127:0] SHAPED_MAX = 128'sd2147483647;
  localparam logic signed [127:0] SHAPED_MIN = -128'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic wr_en = 1'b0;
  logic [tps_pkg::CFG_ADDR_BITS-1:0] wr_addr = '0;
  logic [tps_pkg::CFG_DATA_BITS-1:0] wr_data = '0;
  tps_pkg::in_t item = '0;
  logic full;
  logic empty;
  tps_pkg::out_t result;

  // shaper state as the block should hold it
  logic [7:0] cfg_rise = 8'd10;
  logic [7:0] cfg_peak = 8'd20;
  logic [15:0] cfg_decay = 16'd2560;
  logic cfg_step = 1'b0;
  logic [31:0] cfg_gain = 32'd41943;
  logic [15:0] hist [tps_pkg::MAX_DELAY];
  logic [7:0] wr_ptr = '0;
  int fill_cnt = 0;
  logic signed [15:0] chan_first = '0;
  logic [31:0] diff_sum = '0;
  logic [63:0] shape_acc = '0;

  tps_pkg::out_t pending_shaped [$];
  int errors = 0;
  int burst_left = 0;
  bit steady_feed = 1'b0;
  bit hold_req = 1'b0;

  trapezoidal_pulse_shaper_unit dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  function automatic logic signed [15:0] tap_value(int unsigned dly, logic signed [15:0] cur);
    logic [7:0] idx;
    if (dly == 0) return cur;
    if (dly > fill_cnt) return chan_first;
    idx = wr_ptr - dly[7:0];
    return hist[idx];
  endfunction

  function automatic tps_pkg::out_t shape_sample(tps_pkg::in_t it);
    logic signed [15:0] v, vk, vl, vkl;
    longint d;
    logic signed [127:0] acc_w, gain_w, prod, q;
    tps_pkg::out_t r;
    if (it.chan_start) begin
      chan_first = it.sample;
      fill_cnt = 0;
      diff_sum = '0;
      shape_acc = '0;
    end
    v = it.sample;
    vk = tap_value(cfg_rise, v);
    vl = tap_value(cfg_peak, v);
    vkl = tap_value(int'(cfg_rise) + int'(cfg_peak), v);
    d = longint'(v) - longint'(vk) - longint'(vl) + longint'(vkl);
    diff_sum = diff_sum + d[31:0];
    if (cfg_step)
      shape_acc = shape_acc + d * 64;
    else
      shape_acc = shape_acc + longint'($signed(diff_sum)) * 64
                  + d * longint'({48'd0, cfg_decay});
    hist[wr_ptr] = it.sample;
    wr_ptr = wr_ptr + 8'd1;
    if (fill_cnt < tps_pkg::MAX_DELAY) fill_cnt++;
    // exact product, then floor shift and clamp to int32
    acc_w = $signed(shape_acc);
    gain_w = {96'd0, cfg_gain};
    prod = acc_w * gain_w;
    q = prod >>> 30;
    if (q > SHAPED_MAX) begin
      r.shaped = 32'sh7FFF_FFFF;
      r.clipped = 1'b1;
    end else if (q < SHAPED_MIN) begin
      r.shaped = 32'sh8000_0000;
      r.clipped = 1'b1;
    end else begin
      r.shaped = q[31:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

  task automatic send_item(input tps_pkg::in_t it);
    int gap;
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_shaped.push_back(shape_sample(it));
    if (!steady_feed) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  // drop the input and wait until every shaped sample is out
  task automatic settle();
    push <= 1'b0;
    while (pending_shaped.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] k, input logic [7:0] l,
                           input logic [15:0] m, input logic step,
                           input logic [31:0] g);
    logic [tps_pkg::CFG_ADDR_BITS-1:0] addrs [5];
    logic [tps_pkg::CFG_DATA_BITS-1:0] vals [5];
    settle();
    addrs = '{tps_pkg::REG_RISE_LEN, tps_pkg::REG_PEAK_DELAY, tps_pkg::REG_DECAY_CONST,
              tps_pkg::REG_STEP_MODE, tps_pkg::REG_OUT_GAIN};
    vals = '{{24'd0, k}, {24'd0, l}, {16'd0, m}, {31'd0, step}, g};
    for (int i = 0; i < 5; i++) begin
      wr_en <= 1'b1;
      wr_addr <= addrs[i];
      wr_data <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
    cfg_rise = k;
    cfg_peak = l;
    cfg_decay = m;
    cfg_step = step;
    cfg_gain = g;
  endtask

  task automatic send_list(input int vals [], input bit start_first);
    tps_pkg::in_t it;
    foreach (vals[i]) begin
      it.sample = 16'(vals[i]);
      it.chan_start = start_first && (i == 0);
      send_item(it);
    end
  endtask

  // channels of pulse trains, noise and rail values
  task automatic run_channels(input int n);
    tps_pkg::in_t it;
    int chan_left, style, base, amp, smp;
    int rails [4];
    bit start;
    rails = '{32767, -32768, 0, -1};
    chan_left = 0;
    style = 0;
    base = 0;
    amp = 0;
    for (int i = 0; i < n; i++) begin
      start = 1'b0;
      if (chan_left == 0 || $urandom_range(0, 99) == 0) begin
        start = 1'b1;
        style = $urandom_range(0, 3);
        chan_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20)
                    : $urandom_range(int'(cfg_rise) + int'(cfg_peak) + 8, 700);
        base = int'($urandom_range(0, 4000)) - 2000;
        amp = 0;
      end
      case (style)
        0: smp = int'($urandom_range(0, 65535)) - 32768;
        3: smp = rails[$urandom_range(0, 3)];
        default: begin
          if ($urandom_range(0, 39) == 0) amp += int'($urandom_range(0, 20000)) - 5000;
          amp = amp - amp / 32;
          smp = base + amp + int'($urandom_range(0, 16)) - 8;
          if (smp > 32767) smp = 32767;
          if (smp < -32768) smp = -32768;
        end
      endcase
      it.sample = smp[15:0];
      it.chan_start = start;
      send_item(it);
      if (chan_left > 0) chan_left--;
    end
  endtask

  task automatic rand_config();
    logic [7:0] k, l;
    logic [15:0] m;
    logic [31:0] g;
    int sel;
    if ($urandom_range(0, 3) == 0) k = 8'($urandom_range(1, 255));
    else k = 8'($urandom_range(1, 32));
    if ($urandom_range(0, 3) == 0) l = 8'($urandom_range(1, 255));
    else l = 8'($urandom_range(k, k + 32));
    m = 16'($urandom);
    sel = $urandom_range(0, 3);
    if (sel < 2 && m != 0) g = 32'((64'd1 << 30) / ({48'd0, m} * {56'd0, k}));
    else if (sel == 2) g = $urandom;
    else g = $urandom_range(0, 1024);
    configure(k, l, m, 1'($urandom_range(0, 1)), g);
  endtask

  // reset register values, counting from reset without a channel start
  task automatic test_reset_defaults();
    send_list('{32767, -32768, 0, -1}, 1'b0);
  endtask

  task automatic test_zero_delay();
    configure(8'd0, 8'd2, 16'd2560, 1'b0, 32'd41943);
    send_list('{-32768, 32767, 1000}, 1'b1);
    configure(8'd3, 8'd0, 16'd64, 1'b0, 32'd1 << 30);
    send_list('{500, -500, 32767}, 1'b1);
  endtask

  // k+l reaches past the delay line
  task automatic test_long_taps();
    configure(8'd255, 8'd255, 16'd0, 1'b1, 32'd1 << 30);
    send_list('{-32768, 32767, 1, -1, 12345, 0}, 1'b1);
  endtask

  task automatic test_saturation();
    configure(8'd1, 8'd2, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    send_list('{32767, 32767, -32768, -32768, 0}, 1'b1);
  endtask

  // hold off the result side while the input keeps pushing
  task automatic test_backpressure();
    configure(8'd10, 8'd20, 16'd2560, 1'b0, 32'd41943);
    hold_req = 1'b1;
    steady_feed = 1'b1;
    run_channels(30);
    steady_feed = 1'b0;
  endtask

  task automatic test_random_settings();
    configure(8'd255, 8'd255, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    run_channels(250);
    configure(8'd1, 8'd1, 16'd0, 1'b1, 32'd0);
    run_channels(100);
    for (int i = 0; i < 6; i++) begin
      rand_config();
      run_channels(230);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_zero_delay();
    test_long_taps();
    test_saturation();
    test_backpressure();
    test_random_settings();
    settle();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_shaped.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // result side: check each popped item, stall on a changing pattern
  initial begin
    tps_pkg::out_t want;
    int mode, mode_left, hold_left, cyc;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!rst && pop && !empty) begin
        if (pending_shaped.size() == 0) begin
          $display("%0t: unexpected result shaped %0d clipped %0b",
                   $time, result.shaped, result.clipped);
          errors++;
        end else begin
          want = pending_shaped.pop_front();
          if (result.shaped !== want.shaped) begin
            $display("%0t: shaped mismatch: expected %0d, actual %0d",
                     $time, want.shaped, result.shaped);
            errors++;
          end
          if (result.clipped !== want.clipped) begin
            $display("%0t: clipped mismatch: expected %0b, actual %0b",
                     $time, want.clipped, result.clipped);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (cyc % 4) == 0;
          default: pop <= (cyc % 32) < 20;
        endcase
      end
    end
  end

endmodule
